### src/aapr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapr_pkg
// Shared types, constants and helpers of the axis-angle point rotator.
// ----------------------------------------------------------------------------
package aapr_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int TRIG_ITERATIONS = 16;
   localparam int PROD_WIDTH      = COORD_WIDTH + 32;
   localparam int ACC_WIDTH       = PROD_WIDTH + 2;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
   localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;

   localparam logic [2:0] CSR_AXIS_X         = 3'd0;
   localparam logic [2:0] CSR_AXIS_Y         = 3'd1;
   localparam logic [2:0] CSR_AXIS_Z         = 3'd2;
   localparam logic [2:0] CSR_ROTATION_ANGLE = 3'd3;

   typedef logic signed [31:0] coef_type;
   typedef coef_type [8:0] matrix_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rotated_x;
      logic signed [COORD_WIDTH-1:0] rotated_y;
      logic signed [COORD_WIDTH-1:0] rotated_z;
      logic                          zero_axis;
      logic                          clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] rotation_angle;
   } axis_cfg_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      BLD_START,
      BLD_REDUCE,
      BLD_CORDIC,
      BLD_NORM,
      BLD_SQRT,
      BLD_MUL1,
      BLD_MUL2,
      BLD_DIV,
      BLD_ASSEMBLE,
      BLD_IDLE
   } build_state_type;

   function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:    val = 30'd843314857;
         5'd1:    val = 30'd497837830;
         5'd2:    val = 30'd263043837;
         5'd3:    val = 30'd133525159;
         5'd4:    val = 30'd67021687;
         5'd5:    val = 30'd33543516;
         5'd6:    val = 30'd16775851;
         5'd7:    val = 30'd8388437;
         5'd8:    val = 30'd4194283;
         5'd9:    val = 30'd2097149;
         5'd10:   val = 30'd1048576;
         5'd11:   val = 30'd524288;
         5'd12:   val = 30'd262144;
         5'd13:   val = 30'd131072;
         5'd14:   val = 30'd65536;
         5'd15:   val = 30'd32768;
         5'd16:   val = 30'd16384;
         5'd17:   val = 30'd8192;
         5'd18:   val = 30'd4096;
         5'd19:   val = 30'd2048;
         5'd20:   val = 30'd1024;
         5'd21:   val = 30'd512;
         5'd22:   val = 30'd256;
         5'd23:   val = 30'd128;
         default: val = 30'd0;
      endcase
      return $signed({6'd0, val});
   endfunction

   function automatic coef_type clamp_unit(input logic signed [35:0] val);
      coef_type res;
      if (val > 36'(ONE_Q30)) begin
         res = 32'(ONE_Q30);
      end else if (val < -36'(ONE_Q30)) begin
         res = -32'(ONE_Q30);
      end else begin
         res = val[31:0];
      end
      return res;
   endfunction

endpackage

### src/axis_angle_point_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_point_rotator
// Rotates Q16.16 points about a configured axis by a configured angle.
// ----------------------------------------------------------------------------
// usage:
//   csr channel: csr_valid/csr_ready with csr_index and 16-bit csr_data;
//   index 0..2 set axis x/y/z (Q8.8), index 3 the angle (Q3.12 radians).
//   csr_ready is always high; other indexes are dropped.
//   each register write starts a rebuild of the rotation matrix (16 CORDIC
//   steps, 32 square root steps and nine divisions in one shared divider);
//   req_stall stays high meanwhile.
//   reset loads axis (32767, 0, 0), angle 0, and runs the same rebuild.
//   req channel: one beat per point; accepted when req_valid and !req_stall.
//   rsp channel: one beat per point, in order, from the output register.
//   throughput: one point per cycle when unstalled; four-stage point pipeline.
//   rsp_stall holds the output register; each stage keeps taking beats while
//   a stage ahead of it is empty, so bubbles fill before req_stall rises.
//   a zero axis passes the point through with zero_axis set.
// ----------------------------------------------------------------------------
module axis_angle_point_rotator import aapr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   axis_cfg_type cfg_ff, cfg_in;
   logic         cfg_hit;
   logic         zero_axis;
   logic         matrix_ready;
   matrix_type   matrix;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in  = cfg_ff;
      cfg_hit = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AXIS_X:         begin cfg_in.axis_x = csr_data; cfg_hit = 1'b1; end
            CSR_AXIS_Y:         begin cfg_in.axis_y = csr_data; cfg_hit = 1'b1; end
            CSR_AXIS_Z:         begin cfg_in.axis_z = csr_data; cfg_hit = 1'b1; end
            CSR_ROTATION_ANGLE: begin
               cfg_in.rotation_angle = csr_data;
               cfg_hit               = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{axis_x: 16'sd32767, axis_y: 16'sd0, axis_z: 16'sd0,
                     rotation_angle: 16'sd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign zero_axis = (cfg_ff.axis_x == 16'sd0) && (cfg_ff.axis_y == 16'sd0)
                    && (cfg_ff.axis_z == 16'sd0);

   aapr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   aapr_matrix_builder u_builder (
      .clock        (clock),
      .reset        (reset),
      .start        (cfg_hit),
      .cfg          (cfg_ff),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .matrix_ready (matrix_ready),
      .matrix       (matrix)
   );

   aapr_point_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .hold      (!matrix_ready),
      .zero_axis (zero_axis),
      .matrix    (matrix),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no point enters while the matrix is being rebuilt
   a_hold_during_build: assert property (@(posedge clock) disable iff (reset)
      !matrix_ready |-> req_stall)
      else $error("point accepted during matrix rebuild");

   // a register write clears matrix_ready, invalidating the matrix
   a_write_invalidates: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> !matrix_ready)
      else $error("matrix still marked ready after register write");

   // pass-through beats never report saturation
   a_zero_no_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_axis |-> !rsp_data.clipped)
      else $error("clipped set on zero-axis beat");

endmodule

### src/aapr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapr_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module aapr_divider import aapr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      diff    = trial - {1'b0, div_req.divisor};
      ge      = trial >= {1'b0, div_req.divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp = '{done: done_ff, quotient: quo_ff};

endmodule

### src/aapr_matrix_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapr_matrix_builder
// Sequencer that forms the rotation matrix: angle reduction, CORDIC,
// squared norm, bit-serial square root and nine rounded quotients.
// ----------------------------------------------------------------------------
module aapr_matrix_builder import aapr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  axis_cfg_type cfg,
   output div_req_type  div_req,
   input  div_rsp_type  div_rsp,
   output logic         matrix_ready,
   output matrix_type   matrix
);

   build_state_type    state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [3:0]         job_ff, job_in;
   logic signed [35:0] z_ff, z_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] c_ff, c_in, s_ff, s_in;
   logic               flip_ff, flip_in;
   logic [31:0]        n2_ff, n2_in;
   logic [63:0]        rad_ff, rad_in;
   logic [31:0]        root_ff, root_in;
   logic [34:0]        rem_ff, rem_in;
   logic signed [31:0] prod1_ff, prod1_in;
   logic [63:0]        num_ff, num_in;
   logic [31:0]        den_ff, den_in;
   logic               go_ff, go_in;
   logic               neg_ff, neg_in;
   logic signed [34:0] q_ff [9];
   logic signed [34:0] q_in;
   logic               q_we;
   matrix_type         matrix_ff, matrix_in;
   logic               ready_ff, ready_in;

   logic signed [15:0] op_a, op_b;
   logic signed [31:0] mul16;
   logic signed [33:0] dx, dy, xn, yn;
   logic signed [35:0] zn;
   logic [31:0]        n2_sum, n2_fix;
   logic [34:0]        rem_next, trial;
   logic [31:0]        root_next;
   logic signed [34:0] t_val, second;
   logic [30:0]        mag1;
   logic [33:0]        mag2;
   logic [64:0]        wide;
   logic [63:0]        prod64;
   logic [31:0]        den_sel;
   logic               d_job;

   // operand select for the shared 16x16 multiplier
   always_comb begin
      op_a = cfg.axis_x;
      op_b = cfg.axis_x;
      if (state_ff == BLD_NORM) begin
         case (cnt_ff[1:0])
            2'd1:    begin op_a = cfg.axis_y; op_b = cfg.axis_y; end
            2'd2:    begin op_a = cfg.axis_z; op_b = cfg.axis_z; end
            default: begin op_a = cfg.axis_x; op_b = cfg.axis_x; end
         endcase
      end else begin
         case (job_ff)
            4'd1:    begin op_a = cfg.axis_y; op_b = cfg.axis_y; end
            4'd2:    begin op_a = cfg.axis_z; op_b = cfg.axis_z; end
            4'd3:    begin op_a = cfg.axis_x; op_b = cfg.axis_y; end
            4'd4:    begin op_a = cfg.axis_x; op_b = cfg.axis_z; end
            4'd5:    begin op_a = cfg.axis_y; op_b = cfg.axis_z; end
            4'd6:    begin op_a = cfg.axis_x; op_b = 16'sd1; end
            4'd7:    begin op_a = cfg.axis_y; op_b = 16'sd1; end
            4'd8:    begin op_a = cfg.axis_z; op_b = 16'sd1; end
            default: begin op_a = cfg.axis_x; op_b = cfg.axis_x; end
         endcase
      end
   end

   always_comb begin
      mul16 = 32'(op_a) * 32'(op_b);

      dx = y_ff >>> cnt_ff[4:0];
      dy = x_ff >>> cnt_ff[4:0];
      if (z_ff >= 0) begin
         xn = x_ff - dx;
         yn = y_ff + dy;
         zn = z_ff - atan_q30(cnt_ff[4:0]);
      end else begin
         xn = x_ff + dx;
         yn = y_ff - dy;
         zn = z_ff + atan_q30(cnt_ff[4:0]);
      end

      n2_sum = n2_ff + mul16[31:0];
      n2_fix = (n2_sum == 32'd0) ? 32'd1 : n2_sum;

      rem_next = {rem_ff[32:0], rad_ff[63:62]};
      trial    = {1'b0, root_ff, 2'b01};

      d_job   = job_ff < 4'd6;
      t_val   = ONE_Q30 - 35'(c_ff);
      second  = d_job ? t_val : 35'(s_ff);
      mag1    = prod1_ff[31] ? 31'(-prod1_ff) : prod1_ff[30:0];
      mag2    = second[34] ? 34'(-second) : second[33:0];
      wide    = 65'(mag1) * 65'(mag2);
      prod64  = d_job ? wide[63:0] : {wide[47:0], 16'd0};
      den_sel = d_job ? n2_ff : root_ff;

      q_in = neg_ff ? -$signed(div_rsp.quotient[34:0]) : $signed(div_rsp.quotient[34:0]);
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      job_in    = job_ff;
      z_in      = z_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      c_in      = c_ff;
      s_in      = s_ff;
      flip_in   = flip_ff;
      n2_in     = n2_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      prod1_in  = prod1_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      go_in     = 1'b0;
      neg_in    = neg_ff;
      q_we      = 1'b0;
      matrix_in = matrix_ff;
      ready_in  = ready_ff;
      root_next = {root_ff[30:0], 1'b0};

      case (state_ff)
         BLD_START: begin
            z_in     = $signed({{2{cfg.rotation_angle[15]}}, cfg.rotation_angle, 18'd0});
            flip_in  = 1'b0;
            ready_in = 1'b0;
            state_in = BLD_REDUCE;
         end
         BLD_REDUCE: begin
            if (z_ff > HALF_PI_Q30) begin
               z_in    = z_ff - PI_Q30;
               flip_in = !flip_ff;
            end else if (z_ff < -HALF_PI_Q30) begin
               z_in    = z_ff + PI_Q30;
               flip_in = !flip_ff;
            end else begin
               x_in     = CORDIC_GAIN;
               y_in     = '0;
               cnt_in   = '0;
               state_in = BLD_CORDIC;
            end
         end
         BLD_CORDIC: begin
            x_in   = xn;
            y_in   = yn;
            z_in   = zn;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(TRIG_ITERATIONS - 1)) begin
               c_in     = flip_ff ? -xn : xn;
               s_in     = flip_ff ? -yn : yn;
               cnt_in   = '0;
               n2_in    = '0;
               state_in = BLD_NORM;
            end
         end
         BLD_NORM: begin
            n2_in  = n2_sum;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               n2_in    = n2_fix;
               rad_in   = {n2_fix, 32'd0};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = BLD_SQRT;
            end
         end
         BLD_SQRT: begin
            if (rem_next >= trial) begin
               rem_in    = rem_next - trial;
               root_next = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_next;
            end
            root_in = root_next;
            rad_in  = {rad_ff[61:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               root_in  = (root_next == 32'd0) ? 32'd1 : root_next;
               job_in   = '0;
               state_in = BLD_MUL1;
            end
         end
         BLD_MUL1: begin
            prod1_in = mul16;
            state_in = BLD_MUL2;
         end
         BLD_MUL2: begin
            num_in   = prod64 + {33'd0, den_sel[31:1]};
            den_in   = den_sel;
            neg_in   = prod1_ff[31] ^ second[34];
            go_in    = 1'b1;
            state_in = BLD_DIV;
         end
         BLD_DIV: begin
            if (div_rsp.done && !go_ff) begin
               q_we = 1'b1;
               if (job_ff == 4'd8) begin
                  state_in = BLD_ASSEMBLE;
               end else begin
                  job_in   = job_ff + 4'd1;
                  state_in = BLD_MUL1;
               end
            end
         end
         BLD_ASSEMBLE: begin
            matrix_in[0] = clamp_unit(36'(c_ff) + 36'(q_ff[0]));
            matrix_in[1] = clamp_unit(36'(q_ff[3]) - 36'(q_ff[8]));
            matrix_in[2] = clamp_unit(36'(q_ff[4]) + 36'(q_ff[7]));
            matrix_in[3] = clamp_unit(36'(q_ff[3]) + 36'(q_ff[8]));
            matrix_in[4] = clamp_unit(36'(c_ff) + 36'(q_ff[1]));
            matrix_in[5] = clamp_unit(36'(q_ff[5]) - 36'(q_ff[6]));
            matrix_in[6] = clamp_unit(36'(q_ff[4]) - 36'(q_ff[7]));
            matrix_in[7] = clamp_unit(36'(q_ff[5]) + 36'(q_ff[6]));
            matrix_in[8] = clamp_unit(36'(c_ff) + 36'(q_ff[2]));
            ready_in     = 1'b1;
            state_in     = BLD_IDLE;
         end
         BLD_IDLE: begin
            ready_in = 1'b1;
         end
         default: begin
            state_in = BLD_START;
         end
      endcase

      if (start) begin
         state_in = BLD_START;
         ready_in = 1'b0;
         q_we     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BLD_START;
         ready_ff <= 1'b0;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         go_ff    <= go_in;
      end
      cnt_ff    <= cnt_in;
      job_ff    <= job_in;
      z_ff      <= z_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      c_ff      <= c_in;
      s_ff      <= s_in;
      flip_ff   <= flip_in;
      n2_ff     <= n2_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      prod1_ff  <= prod1_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      matrix_ff <= matrix_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_ff[job_ff] <= q_in;
      end
   end

   assign div_req      = '{start: go_ff, dividend: num_ff, divisor: den_ff};
   assign matrix_ready = ready_ff;
   assign matrix       = matrix_ff;

endmodule

### src/aapr_point_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapr_point_pipe
// Four-stage point pipeline: capture, nine products, row sums with
// rounding, then shift and saturate into the output register.
// ----------------------------------------------------------------------------
module aapr_point_pipe import aapr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       hold,
   input  logic       zero_axis,
   input  matrix_type matrix,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(64'sd536870912);

   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    adv1, adv2, adv3, adv4;
   logic    take;
   req_type p1_ff, p2_ff, p3_ff;
   logic    z1_ff, z2_ff, z3_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff [9];
   logic signed [ACC_WIDTH-1:0]  acc_ff [3];
   rsp_type out_ff, out_in;

   logic signed [COORD_WIDTH-1:0] pt [3];
   logic signed [ACC_WIDTH-1:0]   sh [3];
   logic [COORD_WIDTH-1:0]        res [3];
   logic [2:0]                    clip;
   logic [ACC_WIDTH-COORD_WIDTH:0] upper;

   assign adv4      = !v4_ff || !rsp_stall;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1 || hold;
   assign take      = req_valid && !req_stall;

   assign pt[0] = p1_ff.point_x;
   assign pt[1] = p1_ff.point_y;
   assign pt[2] = p1_ff.point_z;

   always_comb begin
      upper = '0;
      for (int k = 0; k < 3; k++) begin
         sh[k]   = acc_ff[k] >>> 30;
         upper   = sh[k][ACC_WIDTH-1:COORD_WIDTH-1];
         clip[k] = !((&upper) || !(|upper));
         if (!clip[k]) begin
            res[k] = sh[k][COORD_WIDTH-1:0];
         end else if (sh[k][ACC_WIDTH-1]) begin
            res[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            res[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end
      end
      if (z3_ff) begin
         out_in = '{rotated_x: p3_ff.point_x, rotated_y: p3_ff.point_y,
                    rotated_z: p3_ff.point_z, zero_axis: 1'b1, clipped: 1'b0};
      end else begin
         out_in = '{rotated_x: res[0], rotated_y: res[1], rotated_z: res[2],
                    zero_axis: 1'b0, clipped: |clip};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= take;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         p1_ff <= req_data;
         z1_ff <= zero_axis;
      end
      if (adv2) begin
         p2_ff <= p1_ff;
         z2_ff <= z1_ff;
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= PROD_WIDTH'(matrix[k]) * PROD_WIDTH'(pt[k % 3]);
         end
      end
      if (adv3) begin
         p3_ff <= p2_ff;
         z3_ff <= z2_ff;
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= ACC_WIDTH'(prod_ff[3*r]) + ACC_WIDTH'(prod_ff[3*r+1])
                       + ACC_WIDTH'(prod_ff[3*r+2]) + ROUND_HALF;
         end
      end
      if (adv4) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = out_ff;

endmodule
